FILE: rtl/ttb_pkg.sv
// Shared types and constants of the timeout timer bank.
package ttb_pkg;

    localparam logic [31:0] MAX_RUNTIME_RST = 32'h8000_0000;

    typedef enum logic [2:0] {
        CMD_CREATE      = 3'd0,
        CMD_RESTART     = 3'd1,
        CMD_STOP        = 3'd2,
        CMD_DESTROY     = 3'd3,
        CMD_DESTROY_NOW = 3'd4,
        CMD_TICK        = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  timer_slot;
        logic [31:0] timeout_ms;
        logic        periodic;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [3:0] fired_slot;
        logic       last;
    } t_out;

    // one RAM entry per slot
    typedef struct packed {
        logic        periodic;
        logic [31:0] timeout;
        logic [31:0] stamp;
    } t_entry;

endpackage

FILE: rtl/ttb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ttb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/timeout_timer_bank_unit.sv
// Top level of the timeout timer bank: command decode, tick scan and sweep.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one command word.
//   Create, restart, stop and both destroys finish in the cycle they are
//   accepted; the block is ready again on the next cycle.
//   A tick walks the slots in index order, a read state and an eval state
//   per slot (RAM read, then compare and write-back of the restamp), then
//   a flush state that sends the final result and clears all slots marked
//   for deletion. The input is not ready after the tick word until the flush
//   is done, and output stalls lengthen the scan.
//   Each firing slot yields one word on o_out_valid / i_out_ready /
//   o_out_data; the final word of a tick carries last = 1. A result is held
//   one firing behind the scan so that last is known when it is sent. The
//   output register lets the scan run on while a word waits; when a second
//   firing needs room and the receiver stalls, the scan holds in place.
//   Configuration (max valid runtime) is written through i_cfg_valid /
//   o_cfg_ready / i_cfg_data, always ready.
//   Reset clears all slot flags and sets the max runtime to 0x80000000;
//   RAM timeouts and stamps are undefined until a create or restart.
module timeout_timer_bank_unit #(
    parameter int NUM_SLOTS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ttb_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ttb_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [31:0]   i_cfg_data
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int EW = $bits(ttb_pkg::t_entry);

    ttb_pkg::t_state       r_state, n_state;
    logic [SW-1:0]         r_idx, n_idx;
    logic [31:0]           r_now, n_now;
    logic [31:0]           r_max;
    logic [NUM_SLOTS-1:0]  r_reg, n_reg;
    logic [NUM_SLOTS-1:0]  r_en, n_en;
    logic [NUM_SLOTS-1:0]  r_del, n_del;
    logic                  r_pend_vld, n_pend_vld;
    logic [3:0]            r_pend_slot, n_pend_slot;
    logic                  r_out_vld, n_out_vld;
    ttb_pkg::t_out         r_out, n_out;

    logic                  ram_we;
    logic [SW-1:0]         ram_waddr;
    ttb_pkg::t_entry       ram_wdata;
    logic                  ram_re;
    ttb_pkg::t_entry       ram_rdata;
    logic [EW-1:0]         ram_rdata_raw;

    logic                  slot_ok;
    logic [SW-1:0]         cmd_slot;
    logic [31:0]           elapsed;
    logic                  eligible;
    logic                  fire;
    logic                  out_free;
    logic                  advance;

    ttb_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = ttb_pkg::t_entry'(ram_rdata_raw);

    assign slot_ok  = {5'b0, i_in_data.timer_slot} < 9'(NUM_SLOTS);
    assign cmd_slot = SW'(i_in_data.timer_slot);
    assign elapsed  = r_now - ram_rdata.stamp;
    assign eligible = r_reg[r_idx] && r_en[r_idx] && !r_del[r_idx];
    assign fire     = eligible && (elapsed >= ram_rdata.timeout) && (elapsed < r_max);
    assign out_free = !r_out_vld || i_out_ready;
    // a firing with a word already pending needs room in the output register
    assign advance  = !fire || !r_pend_vld || out_free;

    assign o_in_ready  = (r_state == ttb_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_now       = r_now;
        n_reg       = r_reg;
        n_en        = r_en;
        n_del       = r_del;
        n_pend_vld  = r_pend_vld;
        n_pend_slot = r_pend_slot;
        n_out_vld   = r_out_vld;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ttb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.command == ttb_pkg::CMD_TICK) begin
                        n_now   = i_in_data.now_ms;
                        n_idx   = '0;
                        n_state = ttb_pkg::ST_READ;
                    end else if (slot_ok) begin
                        case (ttb_pkg::t_cmd'(i_in_data.command))
                            ttb_pkg::CMD_CREATE, ttb_pkg::CMD_RESTART: begin
                                ram_we            = 1'b1;
                                ram_waddr         = cmd_slot;
                                ram_wdata.periodic = i_in_data.periodic;
                                ram_wdata.timeout = i_in_data.timeout_ms;
                                ram_wdata.stamp   = i_in_data.now_ms;
                                n_en[cmd_slot]    = 1'b1;
                                n_del[cmd_slot]   = 1'b0;
                                if (i_in_data.command == ttb_pkg::CMD_CREATE) begin
                                    n_reg[cmd_slot] = 1'b1;
                                end
                            end
                            ttb_pkg::CMD_STOP: begin
                                n_en[cmd_slot] = 1'b0;
                            end
                            ttb_pkg::CMD_DESTROY: begin
                                if (r_reg[cmd_slot]) begin
                                    n_en[cmd_slot]  = 1'b0;
                                    n_del[cmd_slot] = 1'b1;
                                end
                            end
                            ttb_pkg::CMD_DESTROY_NOW: begin
                                if (r_reg[cmd_slot]) begin
                                    n_reg[cmd_slot] = 1'b0;
                                    n_en[cmd_slot]  = 1'b0;
                                    n_del[cmd_slot] = 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            ttb_pkg::ST_READ: begin
                ram_re  = 1'b1;
                n_state = ttb_pkg::ST_EVAL;
            end
            ttb_pkg::ST_EVAL: begin
                // read data holds while stalled: no new read is issued here
                if (advance) begin
                    if (fire) begin
                        if (ram_rdata.periodic) begin
                            ram_we          = 1'b1;
                            ram_wdata.stamp = r_now;
                        end else begin
                            n_del[r_idx] = 1'b1;
                        end
                        if (r_pend_vld) begin
                            n_out_vld       = 1'b1;
                            n_out.fired_slot = r_pend_slot;
                            n_out.last      = 1'b0;
                        end
                        n_pend_vld  = 1'b1;
                        n_pend_slot = 4'(r_idx);
                    end
                    if (r_idx == SW'(NUM_SLOTS - 1)) begin
                        n_state = ttb_pkg::ST_FLUSH;
                    end else begin
                        n_idx   = r_idx + SW'(1);
                        n_state = ttb_pkg::ST_READ;
                    end
                end
            end
            ttb_pkg::ST_FLUSH: begin
                if (!r_pend_vld || out_free) begin
                    if (r_pend_vld) begin
                        n_out_vld        = 1'b1;
                        n_out.fired_slot = r_pend_slot;
                        n_out.last       = 1'b1;
                        n_pend_vld       = 1'b0;
                    end
                    // drop every registered slot marked for deletion
                    for (int s = 0; s < NUM_SLOTS; s++) begin
                        if (r_reg[s] && r_del[s]) begin
                            n_reg[s] = 1'b0;
                            n_en[s]  = 1'b0;
                            n_del[s] = 1'b0;
                        end
                    end
                    n_state = ttb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ttb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ttb_pkg::ST_IDLE;
            r_idx      <= '0;
            r_max      <= ttb_pkg::MAX_RUNTIME_RST;
            r_reg      <= '0;
            r_en       <= '0;
            r_del      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_reg      <= n_reg;
            r_en       <= n_en;
            r_del      <= n_del;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_pend_slot <= n_pend_slot;
        r_out       <= n_out;
    end

endmodule

FILE: rtl/ttb_checker.sv
// Port-level checker for the timeout timer bank, bound to the top level.
module ttb_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input ttb_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ttb_pkg::t_out o_out_data,
    input logic          o_cfg_ready
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // the input is ready again in the cycle after a set-up command
    a_cmd_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.command != ttb_pkg::CMD_TICK)
        |=> o_in_ready)
        else $error("block busy after a set-up command");

    // a tick blocks the input while it scans
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.command == ttb_pkg::CMD_TICK)
        |=> !o_in_ready)
        else $error("input ready during a tick scan");

    // more results of the same tick follow a word that is not last
    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> !o_in_ready)
        else $error("tick ended without a final result");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind timeout_timer_bank_unit ttb_checker u_ttb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .o_cfg_ready (o_cfg_ready)
);

FILE: verif/tb.sv
// Testbench for the timeout timer bank: random command words, tick prediction, fired-slot checks.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 16;
    localparam int WATCHDOG = 2000;
    localparam int SETTLE = 40;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    ttb_pkg::t_in  i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    ttb_pkg::t_out o_out_data;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [31:0]   i_cfg_data = '0;

    timeout_timer_bank_unit #(.NUM_SLOTS(NSLOT)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // timer bank mirror
    bit [NSLOT-1:0] slot_reg = '0;
    bit [NSLOT-1:0] slot_en = '0;
    bit [NSLOT-1:0] slot_del = '0;
    bit [NSLOT-1:0] slot_per = '0;
    logic [31:0]    slot_tmo [NSLOT];
    logic [31:0]    slot_stamp [NSLOT];
    logic [31:0]    max_runtime = ttb_pkg::MAX_RUNTIME_RST;

    ttb_pkg::t_in  cmd_words [$];
    ttb_pkg::t_out expected_fires [$];

    bit            idle_on = 1'b1;
    logic [31:0]   clock_ms = 32'd1000;
    int            gap = 0;
    int            stall = 0;
    int            quiet = 0;
    int            n_words = 0;
    int            n_ticks = 0;
    int            n_fired = 0;
    int            n_err = 0;
    int            n_cfg = 0;
    ttb_pkg::t_out want;

    initial begin
        for (int s = 0; s < NSLOT; s++) begin
            slot_tmo[s] = '0;
            slot_stamp[s] = '0;
        end
    end

    function automatic void note_error(string msg);
        n_err++;
        if (n_err <= 10)
            $display("mismatch: %s", msg);
    endfunction

    // apply one accepted command word, queue the fired slots a tick produces
    function automatic void advance_timers(ttb_pkg::t_in w);
        logic [31:0]    elapsed;
        bit [NSLOT-1:0] hit;
        ttb_pkg::t_out  r;
        hit = '0;
        case (w.command)
            ttb_pkg::CMD_TICK: begin
                for (int s = 0; s < NSLOT; s++) begin
                    if (slot_reg[s] && slot_en[s] && !slot_del[s]) begin
                        elapsed = w.now_ms - slot_stamp[s];
                        if (elapsed >= slot_tmo[s] && elapsed < max_runtime) begin
                            hit[s] = 1'b1;
                            if (slot_per[s])
                                slot_stamp[s] = w.now_ms;
                            else
                                slot_del[s] = 1'b1;
                        end
                    end
                end
                for (int s = 0; s < NSLOT; s++) begin
                    if (hit[s]) begin
                        r.fired_slot = 4'(s);
                        r.last = ((hit >> (s + 1)) == '0);
                        expected_fires.push_back(r);
                    end
                end
                // sweep everything marked for deletion
                for (int s = 0; s < NSLOT; s++) begin
                    if (slot_reg[s] && slot_del[s]) begin
                        slot_reg[s] = 1'b0;
                        slot_en[s] = 1'b0;
                        slot_del[s] = 1'b0;
                    end
                end
            end
            ttb_pkg::CMD_CREATE, ttb_pkg::CMD_RESTART: begin
                slot_tmo[w.timer_slot] = w.timeout_ms;
                slot_stamp[w.timer_slot] = w.now_ms;
                slot_per[w.timer_slot] = w.periodic;
                slot_en[w.timer_slot] = 1'b1;
                slot_del[w.timer_slot] = 1'b0;
                if (w.command == ttb_pkg::CMD_CREATE)
                    slot_reg[w.timer_slot] = 1'b1;
            end
            ttb_pkg::CMD_STOP: slot_en[w.timer_slot] = 1'b0;
            ttb_pkg::CMD_DESTROY: begin
                if (slot_reg[w.timer_slot]) begin
                    slot_en[w.timer_slot] = 1'b0;
                    slot_del[w.timer_slot] = 1'b1;
                end
            end
            ttb_pkg::CMD_DESTROY_NOW: begin
                if (slot_reg[w.timer_slot]) begin
                    slot_reg[w.timer_slot] = 1'b0;
                    slot_en[w.timer_slot] = 1'b0;
                    slot_del[w.timer_slot] = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                advance_timers(i_in_data);
                n_words++;
                if (i_in_data.command == ttb_pkg::CMD_TICK)
                    n_ticks++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    i_in_valid <= 1'b0;
                end else if (cmd_words.size() != 0) begin
                    if (idle_on && $urandom_range(0, 7) == 0) begin
                        gap <= $urandom_range(1, 14);
                        i_in_valid <= 1'b0;
                    end else begin
                        i_in_valid <= 1'b1;
                        i_in_data <= cmd_words.pop_front();
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side: ready with random stall bursts, check each word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall <= 0;
        end else begin
            if (stall != 0) begin
                stall <= stall - 1;
                i_out_ready <= (stall == 1);
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall <= $urandom_range(1, 14);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                n_fired++;
                if (expected_fires.size() == 0) begin
                    note_error($sformatf("unexpected word slot=%0d last=%0b",
                                         o_out_data.fired_slot, o_out_data.last));
                end else begin
                    want = expected_fires.pop_front();
                    if (o_out_data.fired_slot !== want.fired_slot)
                        note_error($sformatf("fired_slot exp %0d got %0d",
                                             want.fired_slot, o_out_data.fired_slot));
                    if (o_out_data.last !== want.last)
                        note_error($sformatf("last exp %0b got %0b (slot %0d)",
                                             want.last, o_out_data.last, want.fired_slot));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_word(logic [2:0] cmd, int slot, logic [31:0] tmo, bit per,
                             logic [31:0] now);
        ttb_pkg::t_in w;
        w.command = cmd;
        w.timer_slot = 4'(slot);
        w.timeout_ms = tmo;
        w.periodic = per;
        w.now_ms = now;
        cmd_words.push_back(w);
    endtask

    function automatic logic [31:0] pick_timeout();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return 32'hFFFF_FFFF;
        if (r < 4)
            return $urandom;
        return $urandom_range(0, 40);
    endfunction

    // well-formed timer traffic, with occasional all-slot bursts and noise
    task automatic fill_random(int count);
        int   added;
        int   r;
        added = 0;
        while (added < count) begin
            if ($urandom_range(0, 24) == 0) begin
                for (int s = 0; s < NSLOT; s++)
                    push_word(ttb_pkg::CMD_CREATE, s, $urandom_range(0, 3),
                              1'($urandom_range(0, 1)), clock_ms);
                clock_ms += 3;
                push_word(ttb_pkg::CMD_TICK, $urandom_range(0, 15), $urandom,
                          1'($urandom_range(0, 1)), clock_ms);
                added += NSLOT + 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 22)
                    push_word(ttb_pkg::CMD_CREATE, $urandom_range(0, 15), pick_timeout(),
                              1'($urandom_range(0, 1)), clock_ms);
                else if (r < 30)
                    push_word(ttb_pkg::CMD_RESTART, $urandom_range(0, 15), pick_timeout(),
                              1'($urandom_range(0, 1)), clock_ms);
                else if (r < 35)
                    push_word(ttb_pkg::CMD_STOP, $urandom_range(0, 15), $urandom,
                              1'($urandom_range(0, 1)), $urandom);
                else if (r < 41)
                    push_word(ttb_pkg::CMD_DESTROY, $urandom_range(0, 15), $urandom,
                              1'($urandom_range(0, 1)), $urandom);
                else if (r < 46)
                    push_word(ttb_pkg::CMD_DESTROY_NOW, $urandom_range(0, 15), $urandom,
                              1'($urandom_range(0, 1)), $urandom);
                else if (r < 49)
                    push_word(r[0] ? CMD_RSVD7 : CMD_RSVD6, $urandom_range(0, 15), $urandom,
                              1'($urandom_range(0, 1)), $urandom);
                else begin
                    // advance time; now and then jump anywhere, wrap included
                    if ($urandom_range(0, 19) == 0)
                        clock_ms = $urandom;
                    else
                        clock_ms += $urandom_range(0, 24);
                    push_word(ttb_pkg::CMD_TICK, $urandom_range(0, 15), $urandom,
                              1'($urandom_range(0, 1)), clock_ms);
                end
                added++;
            end
        end
    endtask

    task automatic wait_drained();
        while (cmd_words.size() != 0 || i_in_valid || expected_fires.size() != 0)
            @(posedge i_clk);
        // a tick with no firing may still be scanning
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_max_runtime(logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        max_runtime = v;
        n_cfg++;
    endtask

    initial begin
        logic [31:0] limit;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset max runtime
        push_word(ttb_pkg::CMD_CREATE, 0, 32'd0, 1'b0, 32'd1000);
        push_word(ttb_pkg::CMD_CREATE, 15, 32'hFFFF_FFFF, 1'b1, 32'd1000);
        push_word(ttb_pkg::CMD_CREATE, 1, 32'd5, 1'b1, 32'd1000);
        push_word(ttb_pkg::CMD_CREATE, 2, 32'd10, 1'b0, 32'd1000);
        push_word(ttb_pkg::CMD_TICK, 0, 32'd0, 1'b0, 32'd1000);
        push_word(ttb_pkg::CMD_TICK, 0, 32'd0, 1'b0, 32'd1005);
        push_word(ttb_pkg::CMD_TICK, 0, 32'd0, 1'b0, 32'd1010);
        push_word(ttb_pkg::CMD_RESTART, 3, 32'd0, 1'b0, 32'd1010);   // unregistered, never fires
        push_word(ttb_pkg::CMD_STOP, 1, 32'd0, 1'b0, 32'd1010);
        push_word(ttb_pkg::CMD_DESTROY, 7, 32'd0, 1'b0, 32'd1010);   // unregistered, dropped
        push_word(ttb_pkg::CMD_CREATE, 4, 32'd2, 1'b0, 32'd1020);
        push_word(ttb_pkg::CMD_DESTROY, 4, 32'd0, 1'b0, 32'd1020);
        push_word(ttb_pkg::CMD_CREATE, 5, 32'd1, 1'b1, 32'd1020);
        push_word(ttb_pkg::CMD_DESTROY_NOW, 5, 32'd0, 1'b0, 32'd1020);
        push_word(ttb_pkg::CMD_TICK, 0, 32'd0, 1'b0, 32'd1030);
        push_word(CMD_RSVD6, 9, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        push_word(CMD_RSVD7, 15, 32'hA5A5_5A5A, 1'b0, 32'h5A5A_A5A5);
        push_word(ttb_pkg::CMD_CREATE, 6, 32'd16, 1'b1, 32'hFFFF_FFF8);
        push_word(ttb_pkg::CMD_CREATE, 8, 32'd0, 1'b1, 32'd0);
        push_word(ttb_pkg::CMD_TICK, 0, 32'd0, 1'b0, 32'd8);           // across the wrap
        push_word(ttb_pkg::CMD_TICK, 0, 32'd0, 1'b0, 32'h8000_0008);   // abnormal elapsed
        push_word(ttb_pkg::CMD_TICK, 15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        push_word(ttb_pkg::CMD_RESTART, 1, 32'd0, 1'b0, 32'd20);
        push_word(ttb_pkg::CMD_TICK, 0, 32'd0, 1'b0, 32'd20);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: limit = 32'hFFFF_FFFF;
                1: limit = 32'd1;
                2: limit = 32'd0;
                3: limit = 32'd200;
                4: limit = ttb_pkg::MAX_RUNTIME_RST;
                default: limit = $urandom_range(20, 5000);
            endcase
            // no idling at the end of the run
            if (p == 5)
                idle_on = 1'b0;
            write_max_runtime(limit);
            clock_ms = $urandom;
            fill_random(55);
            wait_drained();
        end

        $display("Ran %0d command words (%0d ticks) across %0d max-runtime writes,",
                 n_words, n_ticks, n_cfg);
        $display("zero and all-ones limits included; %0d fired-slot words checked, %0d errors.",
                 n_fired, n_err);
        if (n_err == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
